### hdl/double_ended_priority_queue_assert.svh
// Assertion macros shared by the RTL
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, switched off while reset is held
`define DPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define DPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hdl/dpq_pkg.sv
package dpq_pkg;

    // field widths
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 72;

    // default store depth
    localparam int CAPACITY_DEF = 16;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 3'd0,
        OP_DELETE_VAL = 3'd1,
        OP_DELETE_MIN = 3'd2,
        OP_DELETE_MAX = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // what every cell does on this beat
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_DELETE_VAL,
        CM_SHIFT_ALL
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       found;
    } t_cell_ctrl;

endpackage

### hdl/dpq_cell.sv
module dpq_cell #(
    parameter int IDX     = 0,
    parameter int COUNT_W = 5
) (
    input  logic                                i_clk,
    input  dpq_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [dpq_pkg::DATA_W-1:0]   i_key,
    input  logic [COUNT_W-1:0]                  i_count,
    input  logic signed [dpq_pkg::DATA_W-1:0]   i_prev_val,
    input  logic                                i_prev_ins,
    input  logic                                i_prev_ge,
    input  logic signed [dpq_pkg::DATA_W-1:0]   i_next_val,
    output logic signed [dpq_pkg::DATA_W-1:0]   o_val,
    output logic                                o_ins,
    output logic                                o_ge,
    output logic                                o_hit,
    output logic signed [dpq_pkg::DATA_W-1:0]   o_tail
);
    import dpq_pkg::*;

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic                     w_occ;
    logic                     w_last;
    logic                     w_gt;

    // local compares against the broadcast key
    assign w_occ  = COUNT_W'(IDX) < i_count;
    assign w_last = w_occ && !(COUNT_W'(IDX + 1) < i_count);
    assign w_gt   = w_occ && (r_val > i_key);
    assign o_ge   = w_occ && (r_val >= i_key);
    // insertion point lies here or to the left
    assign o_ins  = w_gt || !w_occ;
    // first cell not below the key holds an equal copy
    assign o_hit  = o_ge && !i_prev_ge && (r_val == i_key);
    assign o_tail = w_last ? r_val : '0;
    assign o_val  = r_val;

    // next content: shift right, take key, shift left or hold
    always_comb begin
        n_val = r_val;
        unique case (i_ctrl.mode)
            CM_INSERT: begin
                if (i_prev_ins) begin
                    n_val = i_prev_val;
                end else if (o_ins) begin
                    n_val = i_key;
                end
            end
            CM_DELETE_VAL: begin
                if (i_ctrl.found && o_ge) begin
                    n_val = i_next_val;
                end
            end
            CM_SHIFT_ALL: begin
                n_val = i_next_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    // entry store, no reset
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### hdl/double_ended_priority_queue.sv
// Channel  Dir  Beat contents (low bit first)
// s_axis   in   tuser: operation[2:0]; tdata: value[31:0]
// m_axis   out  tdata: min_value[31:0], max_value[63:32], count[68:64],
//               status[70:69], zero pad[71]
//
// One beat per clock while s_axis_tready is high: every operation is applied in the cell row on its beat.
// The result sits in an output register; s_axis_tready drops only while that
// result is held and m_axis_tready is low.
// Reset (synchronous, active low) empties the queue; stored words are kept
// but unread until rewritten.
`include "double_ended_priority_queue_assert.svh"

module double_ended_priority_queue #(
    parameter int CAPACITY = dpq_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dpq_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // value
    input  logic [dpq_pkg::OP_W-1:0]          s_axis_tuser,   // operation
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dpq_pkg::OUT_DATA_W-1:0]    m_axis_tdata    // min, max, count, status, pad
);
    import dpq_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic                     w_s_acc;
    t_op                      w_op;
    logic signed [DATA_W-1:0] w_key;
    t_cell_ctrl               w_ctrl;
    logic                     w_empty;
    logic                     w_full;
    logic                     w_found;
    logic signed [DATA_W-1:0] w_min;
    logic signed [DATA_W-1:0] w_max;

    logic signed [DATA_W-1:0] w_val  [CAPACITY];
    logic signed [DATA_W-1:0] w_tail [CAPACITY];
    logic [CAPACITY-1:0]      w_ins;
    logic [CAPACITY-1:0]      w_ge;
    logic [CAPACITY-1:0]      w_hit;

    logic [COUNT_W-1:0]       r_count;
    logic [COUNT_W-1:0]       n_count;
    t_status                  r_status;
    t_status                  n_status;
    logic                     r_out_valid;
    logic                     n_out_valid;

    // handshake
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);
    assign w_key         = $signed(s_axis_tdata[DATA_W-1:0]);
    assign w_empty       = (r_count == '0);
    assign w_full        = (r_count == COUNT_W'(CAPACITY));
    assign w_found       = |w_hit;

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        dpq_cell #(
            .IDX     (g),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_key      (w_key),
            .i_count    (r_count),
            .i_prev_val ((g == 0) ? '0 : w_val[(g == 0) ? 0 : g - 1]),
            .i_prev_ins ((g == 0) ? 1'b0 : w_ins[(g == 0) ? 0 : g - 1]),
            .i_prev_ge  ((g == 0) ? 1'b0 : w_ge[(g == 0) ? 0 : g - 1]),
            .i_next_val (w_val[(g == CAPACITY - 1) ? g : g + 1]),
            .o_val      (w_val[g]),
            .o_ins      (w_ins[g]),
            .o_ge       (w_ge[g]),
            .o_hit      (w_hit[g]),
            .o_tail     (w_tail[g])
        );
    end

    // cell commands, count and status for this beat
    always_comb begin
        w_ctrl.mode  = CM_HOLD;
        w_ctrl.found = w_found;
        n_count      = r_count;
        n_status     = ST_OK;
        if (w_s_acc) begin
            unique case (w_op)
                OP_INSERT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.mode = CM_INSERT;
                        n_count     = r_count + COUNT_W'(1);
                    end
                end
                OP_DELETE_VAL: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else if (!w_found) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        w_ctrl.mode = CM_DELETE_VAL;
                        n_count     = r_count - COUNT_W'(1);
                    end
                end
                OP_DELETE_MIN: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctrl.mode = CM_SHIFT_ALL;
                        n_count     = r_count - COUNT_W'(1);
                    end
                end
                OP_DELETE_MAX: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - COUNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end
                    n_count = '0;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // output valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_s_acc) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (w_s_acc) begin
                r_status <= n_status;
            end
        end
    end

    // min from the head cell, max from the cell marked as tail
    always_comb begin
        w_max = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_max = w_max | w_tail[i];
        end
    end
    assign w_min = w_empty ? '0 : w_val[0];

    // the store only moves on a beat that also replaces the result, so the
    // live head and tail match the held result
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_status, COUNT_OUT_W'(r_count), w_max, w_min};

    // checks
    `DPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= COUNT_W'(CAPACITY), "count beyond capacity")
    `DPQ_ASSERT(a_hit_single, i_clk, i_rst_n, $onehot0(w_hit), "more than one delete point")
    `DPQ_ASSERT(a_clear_empties, i_clk, i_rst_n, (w_s_acc && w_op == OP_CLEAR) |=> (r_count == '0), "clear left entries")
    `DPQ_ASSERT(a_full_refused, i_clk, i_rst_n, (w_s_acc && w_op == OP_INSERT && w_full) |=> (r_count == $past(r_count) && r_status == ST_FULL), "insert into full store taken")
    `DPQ_ASSERT_ALWAYS(a_no_overrun, i_clk, w_s_acc |-> (!r_out_valid || m_axis_tready), "beat taken over pending result")

endmodule
